/* rtl/core/pagerank_power_iteration_macros.svh */
// assertion macros shared by the pagerank power iteration rtl
// no dependencies; included by files that carry assertions
`ifndef PAGERANK_POWER_ITERATION_MACROS_SVH
`define PAGERANK_POWER_ITERATION_MACROS_SVH

// same-cycle implication
`define PR_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define PR_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

/* rtl/core/pr_pkg.sv */
// shared types and constants for the pagerank power iteration block
// no dependencies
package pr_pkg;
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int NCNT_W = NODE_W + 1;
	localparam int EDGE_W = $clog2(MAX_EDGES);
	localparam int ECNT_W = EDGE_W + 1;
	localparam int WT_W = 17;
	localparam int RANK_W = 32;
	localparam int SUM_W = 48;
	localparam int EDGE_DATA_W = 2 * NODE_W + WT_W;
	localparam logic [WT_W-1:0] ONE_Q16 = WT_W'(65536);
	localparam logic [RANK_W-1:0] ONE_Q31 = 32'h8000_0000;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_RUN = 2'd1,
		REQ_READ = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RES_RUN = 2'd0,
		RES_READ = 2'd1,
		RES_REJECT = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		CFG_NODES = 2'd0,
		CFG_DAMP = 2'd1,
		CFG_THRESH = 2'd2,
		CFG_CAP = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

/* rtl/core/pagerank_power_iteration.sv */
// pagerank power iteration: edge store, rank stores and run sequencer
// depends on pr_pkg, pr_ram, pr_div and pagerank_power_iteration_macros.svh
//
// usage: items arrive on in_valid/in_stall with req_type, src_node, dst_node
// and edge_weight. an edge load writes the edge store and gives no result
// unless the store is full (result kind reject). a clear resets the edge
// count. a rank read gives its result after the read state. a run uses two
// dividers for the initial rank and teleport term, writes each node's
// initial rank, then per pass walks the stored edges (skipping those outside
// the nodes in use) as a read-modify-write of the next-rank ram per edge,
// then updates each node. one result per run is given on out_valid/out_stall
// when it stops. the block takes one item at a time: in_stall is high while
// an item is at work or a result waits; a stalled result holds until the
// transfer. configuration is written on cfg_we with cfg_idx and cfg_data;
// the user must write it only while idle; the block does not enforce this.
// reset clears the edge count and rank fill count and loads the configuration
// defaults, so ranks read as zero until a run covers them; no clearing pass.
module pagerank_power_iteration
	import pr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [NODE_W-1:0]   src_node,
	input  logic [NODE_W-1:0]   dst_node,
	input  logic [WT_W-1:0]     edge_weight,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          result_kind,
	output logic [NODE_W-1:0]   node_id,
	output logic [RANK_W-1:0]   rank_value,
	output logic [15:0]         iterations,
	output logic                run_status,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_data
);
	`include "pagerank_power_iteration_macros.svh"

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_READ = 12'b0000_0000_0010,
		ST_DIV  = 12'b0000_0000_0100,
		ST_INIT = 12'b0000_0000_1000,
		ST_E0   = 12'b0000_0001_0000,
		ST_E1   = 12'b0000_0010_0000,
		ST_E2   = 12'b0000_0100_0000,
		ST_E3   = 12'b0000_1000_0000,
		ST_A0   = 12'b0001_0000_0000,
		ST_A1   = 12'b0010_0000_0000,
		ST_A2   = 12'b0100_0000_0000,
		ST_CHK  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [NCNT_W-1:0] node_count_q;
	logic [WT_W-1:0]   damping_q;
	logic [31:0]       thresh_q;
	logic [15:0]       cap_q;

	logic [ECNT_W-1:0] edge_cnt_q;
	logic [NCNT_W-1:0] rank_fill_q;
	logic [ECNT_W-1:0] e_q;
	logic [NCNT_W-1:0] i_q;
	logic [15:0]       pass_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NODE_W-1:0] t_q;
	logic [WT_W-1:0]   wt_q;
	logic [RANK_W:0]   term_q;
	logic [RANK_W-1:0] nxt_q;
	logic [RANK_W:0]   damped_q;
	logic [RANK_W-1:0] old_q;
	logic              rd_ok_q;
	logic [NODE_W-1:0] rd_node_q;

	logic              out_valid_q;
	res_t              kind_q;
	logic [NODE_W-1:0] node_id_q;
	logic [RANK_W-1:0] rank_q;
	logic [15:0]       iter_q;
	logic              status_q;

	logic [NCNT_W-1:0] n_use;
	logic [WT_W-1:0]   d_use;
	logic [15:0]       cap_use;
	logic              in_xfer;
	logic              out_xfer;

	div_ctl_t          div_init;
	div_ctl_t          div_tele;
	logic [31:0]       init_quo;
	logic [31:0]       tele_quo;
	logic [31:0]       tele_dividend;

	logic                   edge_we;
	logic [EDGE_DATA_W-1:0] edge_rd;
	logic [NODE_W-1:0]      e_src;
	logic [NODE_W-1:0]      e_dst;
	logic [WT_W-1:0]        e_wt;

	logic              rank_we;
	logic [NODE_W-1:0] rank_waddr;
	logic [RANK_W-1:0] rank_wdata;
	logic [NODE_W-1:0] rank_raddr;
	logic [RANK_W-1:0] rank_rd;

	logic              nxt_we;
	logic [NODE_W-1:0] nxt_waddr;
	logic [RANK_W-1:0] nxt_wdata;
	logic [NODE_W-1:0] nxt_raddr;
	logic [RANK_W-1:0] nxt_rd;

	logic [RANK_W+1:0] acc_sum;
	logic [RANK_W+1:0] new_sum;
	logic [RANK_W-1:0] new_rank;
	logic [RANK_W-1:0] diff;
	logic [SUM_W:0]    sum_next;
	logic              last_node;

	always_comb begin
		n_use = node_count_q;
		if (node_count_q == '0) begin
			n_use = NCNT_W'(1);
		end else if (node_count_q > NCNT_W'(MAX_NODES)) begin
			n_use = NCNT_W'(MAX_NODES);
		end
	end
	assign d_use = (damping_q > ONE_Q16) ? ONE_Q16 : damping_q;
	assign cap_use = (cap_q == 16'd0) ? 16'd1 : cap_q;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	assign tele_dividend = {d_use == '0 ? 1'b1 : 1'b0, 31'd0} |
		32'({ONE_Q16 - d_use} << 15);

	assign div_init.start = in_xfer && (req_type == REQ_RUN);
	assign div_tele.start = div_init.start;

	pr_div u_div_init (
		.clk(clk), .arst_n(arst_n), .start(div_init.start), .dividend(ONE_Q31),
		.divisor(n_use), .busy(div_init.busy), .quotient(init_quo)
	);
	pr_div u_div_tele (
		.clk(clk), .arst_n(arst_n), .start(div_tele.start), .dividend(tele_dividend),
		.divisor(n_use), .busy(div_tele.busy), .quotient(tele_quo)
	);

	assign edge_we = in_xfer && (req_type == REQ_LOAD) &&
		(edge_cnt_q < ECNT_W'(MAX_EDGES));
	assign {e_src, e_dst, e_wt} = edge_rd;

	pr_ram #(.WIDTH(EDGE_DATA_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_cnt_q[EDGE_W-1:0]),
		.wdata({src_node, dst_node, edge_weight}),
		.raddr(e_q[EDGE_W-1:0]), .rdata(edge_rd)
	);

	assign acc_sum = {2'b00, nxt_q} + {1'b0, term_q};
	assign new_sum = {1'b0, damped_q} + {2'b00, tele_quo};
	assign new_rank = new_sum[RANK_W+1:RANK_W] != 2'b00 ? '1 : new_sum[RANK_W-1:0];
	assign diff = (new_rank >= old_q) ? new_rank - old_q : old_q - new_rank;
	assign sum_next = {1'b0, sum_q} + (SUM_W+1)'(diff);
	assign last_node = (i_q + NCNT_W'(1)) >= n_use;

	always_comb begin
		rank_we = 1'b0;
		rank_waddr = i_q[NODE_W-1:0];
		rank_wdata = init_quo;
		rank_raddr = i_q[NODE_W-1:0];
		nxt_we = 1'b0;
		nxt_waddr = i_q[NODE_W-1:0];
		nxt_wdata = '0;
		nxt_raddr = i_q[NODE_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				rank_raddr = dst_node;
			end
			ST_INIT: begin
				rank_we = 1'b1;
				nxt_we = 1'b1;
			end
			ST_E1: begin
				rank_raddr = e_src;
				nxt_raddr = e_dst;
			end
			ST_E3: begin
				nxt_we = 1'b1;
				nxt_waddr = t_q;
				nxt_wdata = acc_sum[RANK_W+1:RANK_W] != 2'b00 ? '1 : acc_sum[RANK_W-1:0];
			end
			ST_A2: begin
				rank_we = 1'b1;
				rank_wdata = new_rank;
				nxt_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	pr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.raddr(rank_raddr), .rdata(rank_rd)
	);
	pr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_next_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rd)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_W'(1);
			damping_q <= WT_W'(55706);
			thresh_q <= 32'd215;
			cap_q <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_NODES:  node_count_q <= cfg_data[NCNT_W-1:0];
				CFG_DAMP:   damping_q <= cfg_data[WT_W-1:0];
				CFG_THRESH: thresh_q <= cfg_data;
				CFG_CAP:    cap_q <= cfg_data[15:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_cnt_q <= '0;
			rank_fill_q <= '0;
			out_valid_q <= 1'b0;
			e_q <= '0;
			i_q <= '0;
			pass_q <= '0;
		end else begin
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (req_t'(req_type))
							REQ_LOAD: begin
								if (edge_we) begin
									edge_cnt_q <= edge_cnt_q + ECNT_W'(1);
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							REQ_CLEAR: edge_cnt_q <= '0;
							REQ_READ:  state_q <= ST_READ;
							REQ_RUN:   state_q <= ST_DIV;
						endcase
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (!div_init.busy && !div_tele.busy) begin
						i_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					i_q <= i_q + NCNT_W'(1);
					if (last_node) begin
						if (n_use > rank_fill_q) begin
							rank_fill_q <= n_use;
						end
						pass_q <= '0;
						e_q <= '0;
						state_q <= ST_E0;
					end
				end
				ST_E0: begin
					if (e_q >= edge_cnt_q) begin
						i_q <= '0;
						state_q <= ST_A0;
					end else begin
						state_q <= ST_E1;
					end
				end
				ST_E1: begin
					if ({1'b0, e_src} >= n_use || {1'b0, e_dst} >= n_use) begin
						e_q <= e_q + ECNT_W'(1);
						state_q <= ST_E0;
					end else begin
						state_q <= ST_E2;
					end
				end
				ST_E2: state_q <= ST_E3;
				ST_E3: begin
					e_q <= e_q + ECNT_W'(1);
					state_q <= ST_E0;
				end
				ST_A0: state_q <= ST_A1;
				ST_A1: state_q <= ST_A2;
				ST_A2: begin
					i_q <= i_q + NCNT_W'(1);
					state_q <= last_node ? ST_CHK : ST_A0;
				end
				ST_CHK: begin
					pass_q <= pass_q + 16'd1;
					e_q <= '0;
					if (sum_q <= SUM_W'(thresh_q) || (pass_q + 16'd1) >= cap_use) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_E0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_ok_q <= ({1'b0, dst_node} < n_use) && ({1'b0, dst_node} < rank_fill_q);
			rd_node_q <= dst_node;
		end
		if (state_q == ST_E1) begin
			t_q <= e_dst;
			wt_q <= e_wt;
		end
		if (state_q == ST_E2) begin
			term_q <= (RANK_W+1)'(({32'd0, wt_q} * {17'd0, rank_rd}) >> 16);
			nxt_q <= nxt_rd;
		end
		if (state_q == ST_E0 && e_q >= edge_cnt_q) begin
			sum_q <= '0;
		end
		if (state_q == ST_A1) begin
			damped_q <= (RANK_W+1)'(({32'd0, d_use} * {17'd0, nxt_rd}) >> 16);
			old_q <= rank_rd;
		end
		if (state_q == ST_A2) begin
			sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
		end
		if (state_q == ST_IDLE && in_xfer && req_type == REQ_LOAD) begin
			kind_q <= RES_REJECT;
			node_id_q <= '0;
			rank_q <= '0;
			iter_q <= '0;
			status_q <= 1'b0;
		end
		if (state_q == ST_READ) begin
			kind_q <= RES_READ;
			node_id_q <= rd_node_q;
			rank_q <= rd_ok_q ? rank_rd : '0;
			iter_q <= '0;
			status_q <= 1'b0;
		end
		if (state_q == ST_CHK) begin
			kind_q <= RES_RUN;
			node_id_q <= '0;
			rank_q <= '0;
			iter_q <= pass_q + 16'd1;
			status_q <= !(sum_q <= SUM_W'(thresh_q));
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign node_id = node_id_q;
	assign rank_value = rank_q;
	assign iterations = iter_q;
	assign run_status = status_q;

	`PR_ASSERT_NOW(a_edge_cnt_range, 1'b1, edge_cnt_q <= ECNT_W'(MAX_EDGES), "edge count overflow")
	`PR_ASSERT_NOW(a_fill_range, 1'b1, rank_fill_q <= NCNT_W'(MAX_NODES), "rank fill overflow")
	`PR_ASSERT_NXT(a_e3_next, state_q == ST_E3, state_q == ST_E0, "edge step lost")
	`PR_ASSERT_NOW(a_busy_no_out, state_q != ST_IDLE && state_q != ST_READ && state_q != ST_CHK, !out_valid_q || $past(out_valid_q), "result during run")
endmodule

/* rtl/core/pr_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module pr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/pr_div.sv */
// restoring divider, one quotient bit per cycle
// depends on pr_pkg
module pr_div
	import pr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	input  logic [NCNT_W-1:0] divisor,
	output logic              busy,
	output logic [31:0]       quotient
);
	logic [5:0]        cnt_q;
	logic [NCNT_W-1:0] rem_q;
	logic [31:0]       quo_q;
	logic [NCNT_W-1:0] div_q;
	logic [NCNT_W:0]   rem_sh;

	assign rem_sh = {rem_q, quo_q[31]};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy) begin
			if (rem_sh >= {1'b0, div_q}) begin
				rem_q <= NCNT_W'(rem_sh - {1'b0, div_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NCNT_W-1:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

/* bench/tb.sv */
// self-checking bench for pagerank_power_iteration: directed and random traffic
// against a scoreboard that recomputes edge loads, runs and rank reads
// depends on pr_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
	import pr_pkg::*;

	localparam longint unsigned RANK_SAT = 64'hFFFF_FFFF;
	localparam longint unsigned SUM_SAT = 64'hFFFF_FFFF_FFFF;
	localparam int LIMIT = 4_000_000;

	typedef struct {
		res_t kind;
		logic [NODE_W-1:0] node;
		logic [RANK_W-1:0] rank;
		logic [15:0] iters;
		logic status;
	} rank_result_t;

	class rank_scoreboard;
		int unsigned e_src[MAX_EDGES];
		int unsigned e_dst[MAX_EDGES];
		int unsigned e_wt[MAX_EDGES];
		int unsigned n_edges;
		longint unsigned rank[MAX_NODES];
		longint unsigned nxt[MAX_NODES];
		int unsigned nodes, damp, thresh, cap;
		rank_result_t pending[$];
		int mismatches, runs, reads, rejects, orphans;

		function new();
			n_edges = 0;
			foreach (rank[i]) rank[i] = 0;
			nodes = 1; damp = 55706; thresh = 215; cap = 1000;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] v);
			case (idx)
				CFG_NODES: nodes = v[10:0];
				CFG_DAMP: damp = v[16:0];
				CFG_THRESH: thresh = v;
				CFG_CAP: cap = v[15:0];
			endcase
		endfunction

		function int unsigned n_used();
			if (nodes == 0) return 1;
			if (nodes > MAX_NODES) return MAX_NODES;
			return nodes;
		endfunction

		function longint unsigned sat32(longint unsigned v);
			return v > RANK_SAT ? RANK_SAT : v;
		endfunction

		function void power_run(output int unsigned passes, output logic capped);
			int unsigned n, d, lim;
			longint unsigned tele, term, nv, sum;
			bit conv;
			n = n_used();
			d = damp > 65536 ? 65536 : damp;
			lim = cap == 0 ? 1 : cap;
			tele = ((64'd65536 - d) << 15) / n;
			for (int i = 0; i < n; i++) rank[i] = 64'd2147483648 / n;
			passes = 0;
			conv = 0;
			while (passes < lim && !conv) begin
				for (int i = 0; i < n; i++) nxt[i] = 0;
				for (int e = 0; e < n_edges; e++) begin
					if (e_src[e] < n && e_dst[e] < n) begin
						term = (longint'(e_wt[e]) * rank[e_src[e]]) >> 16;
						nxt[e_dst[e]] = sat32(nxt[e_dst[e]] + term);
					end
				end
				sum = 0;
				for (int i = 0; i < n; i++) begin
					nv = sat32(((longint'(d) * nxt[i]) >> 16) + tele);
					sum += nv >= rank[i] ? nv - rank[i] : rank[i] - nv;
					if (sum > SUM_SAT) sum = SUM_SAT;
					rank[i] = nv;
				end
				passes++;
				if (sum <= thresh) conv = 1;
			end
			capped = !conv;
		endfunction

		function void note_item(req_t req, int unsigned s, int unsigned d, int unsigned w);
			rank_result_t r;
			int unsigned p;
			logic c;
			r = '{RES_RUN, '0, '0, '0, 1'b0};
			case (req)
				REQ_LOAD: begin
					if (n_edges >= MAX_EDGES) begin
						r.kind = RES_REJECT;
						rejects++;
						pending.push_back(r);
					end else begin
						e_src[n_edges] = s; e_dst[n_edges] = d; e_wt[n_edges] = w;
						n_edges++;
					end
				end
				REQ_CLEAR: n_edges = 0;
				REQ_READ: begin
					r.kind = RES_READ;
					r.node = d;
					r.rank = d < n_used() ? rank[d][31:0] : '0;
					reads++;
					pending.push_back(r);
				end
				REQ_RUN: begin
					power_run(p, c);
					r.iters = p[15:0];
					r.status = c;
					runs++;
					pending.push_back(r);
				end
			endcase
		endfunction

		function void check_result(rank_result_t got);
			rank_result_t exp;
			if (pending.size() == 0) begin
				orphans++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind %0d node %0d rank %h",
						got.kind, got.node, got.rank);
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind || got.node !== exp.node || got.rank !== exp.rank ||
					got.iters !== exp.iters || got.status !== exp.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp kind %0d node %0d rank %h iter %0d st %0d, got kind %0d node %0d rank %h iter %0d st %0d",
						exp.kind, exp.node, exp.rank, exp.iters, exp.status,
						got.kind, got.node, got.rank, got.iters, got.status);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [NODE_W-1:0] src_node = '0;
	logic [NODE_W-1:0] dst_node = '0;
	logic [WT_W-1:0] edge_weight = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] result_kind;
	logic [NODE_W-1:0] node_id;
	logic [RANK_W-1:0] rank_value;
	logic [15:0] iterations;
	logic run_status;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	rank_scoreboard sb;
	bit calm;
	int cycles;
	int transfers;

	pagerank_power_iteration dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .src_node(src_node), .dst_node(dst_node),
		.edge_weight(edge_weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .node_id(node_id), .rank_value(rank_value),
		.iterations(iterations), .run_status(run_status),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= !calm && $urandom_range(99) < 7;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{res_t'(result_kind), node_id, rank_value, iterations, run_status});
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task send(req_t r, int unsigned s, int unsigned d, int unsigned w);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		req_type <= r;
		src_node <= s;
		dst_node <= d;
		edge_weight <= w;
		do @(posedge clk); while (in_stall);
		sb.note_item(r, s, d, w);
		transfers++;
	endtask

	task settle();
		@(negedge clk);
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task random_phase(int items);
		int unsigned n, s, d, w, k;
		write_reg(CFG_NODES, $urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(1, 12));
		write_reg(CFG_DAMP, $urandom_range(65536));
		k = $urandom_range(2);
		write_reg(CFG_THRESH, k == 0 ? 0 : (k == 1 ? $urandom_range(5000) : $urandom));
		write_reg(CFG_CAP, $urandom_range(1, 40));
		n = sb.n_used();
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(99);
			s = $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(n + 1);
			d = $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(n + 1);
			w = $urandom_range(9) == 0 ? 65536 : $urandom_range(65536);
			if (k < 45) send(REQ_LOAD, s, d, w);
			else if (k < 53) send(REQ_RUN, s, d, w);
			else if (k < 93) send(REQ_READ, s, d, w);
			else send(REQ_CLEAR, s, d, w);
		end
		send(REQ_RUN, 0, 0, 0);
		settle();
	endtask

	initial begin
		sb = new();
		calm = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// reset values, then a small ring with edges outside the nodes in use
		send(REQ_READ, 0, 0, 0);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 0, 0);
		settle();
		write_reg(CFG_NODES, 4);
		send(REQ_LOAD, 0, 1, 65536);
		send(REQ_LOAD, 1, 2, 65536);
		send(REQ_LOAD, 2, 3, 32768);
		send(REQ_LOAD, 3, 0, 65536);
		send(REQ_LOAD, 2, 0, 32768);
		send(REQ_LOAD, 5, 0, 65536);
		send(REQ_LOAD, 0, 1023, 0);
		send(REQ_RUN, 0, 0, 0);
		for (int i = 0; i < 4; i++) send(REQ_READ, 0, i, 0);
		send(REQ_READ, 0, 9, 0);
		send(REQ_READ, 1023, 1023, 65536);
		send(REQ_CLEAR, 0, 0, 0);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 2, 0);
		settle();

		// register extremes
		write_reg(CFG_DAMP, 32'h1FFFF);
		write_reg(CFG_THRESH, 0);
		write_reg(CFG_CAP, 0);
		send(REQ_LOAD, 1, 0, 65536);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 0, 0);
		settle();
		write_reg(CFG_NODES, 0);
		write_reg(CFG_THRESH, 32'hFFFF_FFFF);
		write_reg(CFG_CAP, 16'hFFFF);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 0, 0);
		settle();
		write_reg(CFG_NODES, 11'h7FF);
		write_reg(CFG_DAMP, 0);
		write_reg(CFG_THRESH, 32'h8000_0000);
		write_reg(CFG_CAP, 2);
		send(REQ_LOAD, 1023, 1023, 65536);
		send(REQ_LOAD, 1023, 512, 65535);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 1023, 0);
		settle();
		write_reg(CFG_NODES, 1024);
		write_reg(CFG_DAMP, 65536);
		write_reg(CFG_THRESH, 0);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_READ, 0, 512, 0);
		settle();

		// fill the edge store, then overflow it
		send(REQ_CLEAR, 0, 0, 0);
		for (int i = 0; i < MAX_EDGES; i++)
			send(REQ_LOAD, $urandom_range(1023), $urandom_range(1023), $urandom_range(65536));
		send(REQ_LOAD, 1023, 1023, 65536);
		send(REQ_LOAD, 0, 0, 0);
		send(REQ_CLEAR, 0, 0, 0);
		send(REQ_LOAD, 0, 0, 65536);
		settle();
		write_reg(CFG_NODES, 1);
		write_reg(CFG_DAMP, 55706);
		write_reg(CFG_THRESH, 215);
		write_reg(CFG_CAP, 1000);
		send(REQ_RUN, 0, 0, 0);
		send(REQ_CLEAR, 0, 0, 0);
		settle();

		for (int p = 0; p < 8; p++) begin
			calm = (p == 3 || p == 4);
			random_phase(135);
		end
		calm = 0;

		settle();
		repeat (50) @(posedge clk);
		$display("%0d transfers in: %0d runs, %0d rank reads, %0d rejected loads",
			transfers, sb.runs, sb.reads, sb.rejects);
		$display("%0d mismatches, %0d unexpected, %0d results outstanding",
			sb.mismatches, sb.orphans, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
